### sv/tabulated_pair_force_assert.svh
// ----------------------------------------------------------------------------
// Tabulated pair force: assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TABULATED_PAIR_FORCE_ASSERT_SVH
`define TABULATED_PAIR_FORCE_ASSERT_SVH

// property must hold at every edge out of reset
`define TPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen
`define TPF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### sv/tpf_pkg.sv
// ----------------------------------------------------------------------------
// Tabulated pair force: package
// Types, widths and register codes shared by the front, back and top.
// ----------------------------------------------------------------------------
package tpf_pkg;

  localparam int unsigned TABLE_BINS_DEF = 8192;
  localparam int unsigned SPECIES_DEF    = 2;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned DIFF_W     = COORD_W + 1;
  localparam int unsigned SQ_W       = 2 * COORD_W + 1;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned R2_W       = 32;
  localparam int unsigned SQRT_STEPS = (R2_W + FRAC_W) / 2;
  localparam int unsigned ROOT_W     = SQRT_STEPS;
  localparam int unsigned QUOT_W     = 33;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned ADDR_W     = 14;
  localparam int unsigned GHOST_W    = 2;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned EN_W       = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned EN_OO   = 0;
  localparam int unsigned EN_SIO  = 1;
  localparam int unsigned EN_SISI = 2;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_PAIR = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_BIN_WIDTH = 3'd0,
    REG_CUTOFF_OO     = 3'd1,
    REG_CUTOFF_SIO    = 3'd2,
    REG_CUTOFF_SISI   = 3'd3,
    REG_PAIR_ENABLE   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic                      command;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic                      first_type;
    logic                      second_type;
    logic [GHOST_W-1:0]        ghost_count;
    logic [WORD_W-1:0]         table_word;
    logic [ADDR_W-1:0]         table_address;
  } in_item_t;

  typedef struct packed {
    logic                      contributes;
    logic signed [COORD_W-1:0] force_x;
    logic signed [COORD_W-1:0] force_y;
    logic signed [COORD_W-1:0] force_z;
    logic signed [COORD_W-1:0] energy_share;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] inv_bin_width;
    logic [CFG_W-1:0] cutoff_oo;
    logic [CFG_W-1:0] cutoff_sio;
    logic [CFG_W-1:0] cutoff_sisi;
    logic [EN_W-1:0]  pair_enable;
  } cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic                          is_pair;
    logic                          contrib;
    logic                          first_type;
    logic                          second_type;
    logic [GHOST_W-1:0]            ghosts;
    logic signed [2:0][DIFF_W-1:0] d;
    logic [R2_W-1:0]               r2;
    logic [ROOT_W-1:0]             root;
    logic [WORD_W-1:0]             table_word;
    logic [ADDR_W-1:0]             table_address;
  } fe_word_t;

endpackage

### sv/tabulated_pair_force.sv
// ----------------------------------------------------------------------------
// Tabulated pair force: top level
// Pair force and energy from per-species-pair bin tables, interpolated.
// ----------------------------------------------------------------------------
// Input queue side: drive in_item_i and raise push; the word is taken on an
// edge where full is low. Command load writes one force/energy word into the
// bin table of the (first_type, second_type) pair; command pair computes.
// Result queue side: while empty is low the oldest result is on out_item_o;
// raise pop to take it. Pairs give one result each, loads give none.
// Configuration: cfg_we_i with cfg_idx_i and cfg_data_i, written at once.
// A pair passes through the 24-step square root in the front and the 33-step
// divider in the back. Throughput: one word per cycle while full is low.
// A load affects every pair pushed after it.
// Reset clears the queues and pipelines and sets the registers to their
// defaults (all pairs enabled); the bin table keeps whatever it held.
// If pop stays low, results pile up in a 4-word output queue, the back end
// then stops, the 4-word middle queue fills, and full rises.
// ----------------------------------------------------------------------------
`include "tabulated_pair_force_assert.svh"

module tabulated_pair_force #(
  parameter int unsigned TABLE_BINS    = tpf_pkg::TABLE_BINS_DEF,
  parameter int unsigned SPECIES_COUNT = tpf_pkg::SPECIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  tpf_pkg::in_item_t             in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output tpf_pkg::out_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic [tpf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tpf_pkg::CFG_W-1:0]     cfg_data_i
);
  import tpf_pkg::*;

  cfg_t      cfg_q;
  logic      in_rdy;
  logic      q_push, q_pop, q_full, q_empty;
  fe_word_t  q_in, q_out;
  logic      o_push, o_full;
  out_item_t o_in;
  logic      out_quiet;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{inv_bin_width: '0, cutoff_oo: '0, cutoff_sio: '0, cutoff_sisi: '0,
                 pair_enable: '1};
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_INV_BIN_WIDTH: cfg_q.inv_bin_width <= cfg_data_i;
        REG_CUTOFF_OO:     cfg_q.cutoff_oo     <= cfg_data_i;
        REG_CUTOFF_SIO:    cfg_q.cutoff_sio    <= cfg_data_i;
        REG_CUTOFF_SISI:   cfg_q.cutoff_sisi   <= cfg_data_i;
        REG_PAIR_ENABLE:   cfg_q.pair_enable   <= cfg_data_i[EN_W-1:0];
        default: ;
      endcase
    end
  end

  assign full = !in_rdy;

  tpf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (push),
    .in_item_i (in_item_i),
    .cfg_i     (cfg_q),
    .in_rdy_o  (in_rdy),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_word_o  (q_in)
  );

  tpf_fifo #(.T(fe_word_t), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .data_o  (q_out)
  );

  tpf_back #(.TABLE_BINS(TABLE_BINS), .SPECIES_COUNT(SPECIES_COUNT)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_word_i        (q_out),
    .q_pop_o         (q_pop),
    .inv_bin_width_i (cfg_q.inv_bin_width),
    .o_full_i        (o_full),
    .o_push_o        (o_push),
    .o_item_o        (o_in)
  );

  tpf_fifo #(.T(out_item_t), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (o_push),
    .data_i  (o_in),
    .pop_i   (pop),
    .full_o  (o_full),
    .empty_o (empty),
    .data_o  (out_item_o)
  );

  assign out_quiet = (out_item_o.force_x == '0) && (out_item_o.force_y == '0)
                     && (out_item_o.force_z == '0) && (out_item_o.energy_share == '0);

  `TPF_ASSERT_NEVER(a_mid_q_overflow, q_push && q_full, "front pushed into full queue")
  `TPF_ASSERT_NEVER(a_out_q_overflow, o_push && o_full, "back pushed into full output queue")
  `TPF_ASSERT(a_quiet_result, (!empty && !out_item_o.contributes) |-> out_quiet, "quiet word has data")

endmodule

### sv/tpf_fifo.sv
// ----------------------------------------------------------------------------
// Tabulated pair force: small register queue
// First-word-fall-through queue; head is valid while empty_o is low.
// ----------------------------------------------------------------------------
module tpf_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output T     data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  T                 mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### sv/tpf_front.sv
// ----------------------------------------------------------------------------
// Tabulated pair force: front end
// Takes words, forms r squared, checks pair enable and cutoff, takes the
// square root of r squared one bit per stage, then hands a classified word on.
// ----------------------------------------------------------------------------
module tpf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_vld_i,
  input  tpf_pkg::in_item_t in_item_i,
  input  tpf_pkg::cfg_t     cfg_i,
  output logic              in_rdy_o,
  input  logic              q_full_i,
  output logic              q_push_o,
  output tpf_pkg::fe_word_t q_word_o
);
  import tpf_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned N_W   = R2_W + FRAC_W;
  localparam int unsigned SUM_W = SQ_W + 2;

  logic adv;

  // stage 1: differences and magnitudes
  logic                     s1_vld_q;
  fe_word_t                 s1_w_q;
  logic [2:0][DIFF_W-1:0]   s1_mag_q;
  // stage 2: squares
  logic                     s2_vld_q;
  fe_word_t                 s2_w_q;
  logic [2:0][SQ_W-1:0]     s2_sq_q;
  // stage 3 onwards: square-root steps
  logic                     sv_q    [SQRT_STEPS+1];
  fe_word_t                 sw_q    [SQRT_STEPS+1];
  logic [REM_W-1:0]         srem_q  [SQRT_STEPS+1];
  logic [ROOT_W-1:0]        sroot_q [SQRT_STEPS+1];

  fe_word_t                 s1_w_d;
  logic [2:0][DIFF_W-1:0]   s1_mag_d;
  logic [2:0][SQ_W-1:0]     s2_sq_d;
  fe_word_t                 s3_w_d;
  logic [SUM_W-1:0]         sum;
  logic [SUM_W-FRAC_W-1:0]  r2_full;
  logic [CFG_W-1:0]         cutoff;
  logic                     enabled;

  assign adv      = !q_full_i || !sv_q[SQRT_STEPS];
  assign in_rdy_o = adv;
  assign q_push_o = sv_q[SQRT_STEPS] && adv;

  always_comb begin
    q_word_o      = sw_q[SQRT_STEPS];
    q_word_o.root = sroot_q[SQRT_STEPS];
  end

  always_comb begin
    logic signed [DIFF_W-1:0] df;
    s1_w_d               = '0;
    s1_w_d.is_pair       = (in_item_i.command == CMD_PAIR);
    s1_w_d.first_type    = in_item_i.first_type;
    s1_w_d.second_type   = in_item_i.second_type;
    s1_w_d.ghosts        = in_item_i.ghost_count;
    s1_w_d.table_word    = in_item_i.table_word;
    s1_w_d.table_address = in_item_i.table_address;
    s1_w_d.d[0] = {in_item_i.first_x[COORD_W-1], in_item_i.first_x}
                - {in_item_i.second_x[COORD_W-1], in_item_i.second_x};
    s1_w_d.d[1] = {in_item_i.first_y[COORD_W-1], in_item_i.first_y}
                - {in_item_i.second_y[COORD_W-1], in_item_i.second_y};
    s1_w_d.d[2] = {in_item_i.first_z[COORD_W-1], in_item_i.first_z}
                - {in_item_i.second_z[COORD_W-1], in_item_i.second_z};
    for (int k = 0; k < 3; k++) begin
      df = s1_w_d.d[k];
      s1_mag_d[k] = df[DIFF_W-1] ? DIFF_W'(-df) : DIFF_W'(df);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s2_sq_d[k] = SQ_W'(SQ_W'(s1_mag_q[k]) * SQ_W'(s1_mag_q[k]));
    end
  end

  // r2 = floor(sum of squares / 2^16); cutoff and enable by species pair
  always_comb begin
    sum     = SUM_W'(s2_sq_q[0]) + SUM_W'(s2_sq_q[1]) + SUM_W'(s2_sq_q[2]);
    r2_full = sum[SUM_W-1:FRAC_W];
    if (!s2_w_q.first_type && !s2_w_q.second_type) begin
      cutoff  = cfg_i.cutoff_oo;
      enabled = cfg_i.pair_enable[EN_OO];
    end else if (s2_w_q.first_type && s2_w_q.second_type) begin
      cutoff  = cfg_i.cutoff_sisi;
      enabled = cfg_i.pair_enable[EN_SISI];
    end else begin
      cutoff  = cfg_i.cutoff_sio;
      enabled = cfg_i.pair_enable[EN_SIO];
    end
    s3_w_d         = s2_w_q;
    s3_w_d.r2      = r2_full[R2_W-1:0];
    s3_w_d.contrib = enabled && (r2_full != '0)
                     && (r2_full <= (SUM_W-FRAC_W)'(cutoff));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      sv_q[0]  <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_vld_i;
      s2_vld_q <= s1_vld_q;
      sv_q[0]  <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_w_q     <= s1_w_d;
      s1_mag_q   <= s1_mag_d;
      s2_w_q     <= s1_w_q;
      s2_sq_q    <= s2_sq_d;
      sw_q[0]    <= s3_w_d;
      srem_q[0]  <= '0;
      sroot_q[0] <= '0;
    end
  end

  // one root bit per stage, two radicand bits consumed each time
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [N_W-1:0]   n;
    logic [REM_W+1:0] cur, trial;
    logic             take;

    always_comb begin
      n     = {sw_q[j].r2, FRAC_W'(0)};
      cur   = {srem_q[j], n[N_W-1-2*j -: 2]};
      trial = (REM_W+2)'({sroot_q[j], 2'b01});
      take  = (cur >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j+1] <= 1'b0;
      end else if (adv) begin
        sv_q[j+1] <= sv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sw_q[j+1]    <= sw_q[j];
        srem_q[j+1]  <= take ? REM_W'(cur - trial) : REM_W'(cur);
        sroot_q[j+1] <= {sroot_q[j][ROOT_W-2:0], take};
      end
    end
  end

endmodule

### sv/tpf_back.sv
// ----------------------------------------------------------------------------
// Tabulated pair force: back end
// Owns the bin table. Loads write it; pairs look up two neighbouring bins,
// interpolate, and scale the force by d/r with a bit-per-stage divider.
// ----------------------------------------------------------------------------
module tpf_back #(
  parameter int unsigned TABLE_BINS    = tpf_pkg::TABLE_BINS_DEF,
  parameter int unsigned SPECIES_COUNT = tpf_pkg::SPECIES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  input  tpf_pkg::fe_word_t      q_word_i,
  output logic                   q_pop_o,
  input  logic [tpf_pkg::CFG_W-1:0] inv_bin_width_i,
  input  logic                   o_full_i,
  output logic                   o_push_o,
  output tpf_pkg::out_item_t     o_item_o
);
  import tpf_pkg::*;

  localparam int unsigned TABLE_LEN = TABLE_BINS + 1;
  localparam int unsigned MEM_DEPTH = SPECIES_COUNT * SPECIES_COUNT * TABLE_LEN;
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
  localparam int unsigned P_W       = R2_W + CFG_W;
  localparam int unsigned HW        = WORD_W / 2;
  localparam int unsigned PROD_W    = DIFF_W + FRAC_W + 1;
  localparam int unsigned N_W       = COORD_W + DIFF_W;

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [QUOT_W-1:0] low;
    logic [QUOT_W-1:0] quot;
  } div_lane_t;

  typedef struct packed {
    logic                      contrib;
    logic signed [COORD_W-1:0] share;
    logic [ROOT_W-1:0]         root;
    logic [2:0]                neg;
    div_lane_t [2:0]           lane;
  } div_t;

  logic adv;

  // table
  logic [WORD_W-1:0] mem_q [MEM_DEPTH];
  logic [WORD_W-1:0] rd0_q, rd1_q;
  logic              we;
  logic [MEM_AW-1:0] waddr, ra0, ra1;

  // stage A
  logic              a_vld_q;
  fe_word_t          a_w_q;
  logic [P_W-1:0]    a_p_q;
  // stage B
  logic              b_vld_q, b_ok_q;
  fe_word_t          b_w_q;
  logic [FRAC_W-1:0] b_t_q;
  // stage C
  logic                     c_vld_q;
  fe_word_t                 c_w_q;
  logic signed [HW-1:0]     c_f0_q, c_e0_q;
  logic signed [PROD_W-1:0] c_fp_q, c_ep_q;
  // stage D
  logic                      d_vld_q;
  fe_word_t                  d_w_q;
  logic signed [COORD_W-1:0] d_f_q, d_share_q;
  // divider
  logic dv_q [QUOT_W+1];
  div_t dd_q [QUOT_W+1];

  logic [MEM_AW-1:0]         a_base, b_base;
  logic [COORD_W-1:0]        bin;
  fe_word_t                  c_w_d;
  logic signed [PROD_W-1:0]  c_fp_d, c_ep_d;
  logic signed [COORD_W-1:0] d_f_d, d_share_d;
  div_t                      e_d;

  assign adv     = !o_full_i || !dv_q[QUOT_W];
  assign q_pop_o = !q_empty_i && adv;
  assign o_push_o = dv_q[QUOT_W] && adv;

  function automatic logic [MEM_AW-1:0] base_of(logic ft, logic st);
    logic [MEM_AW-1:0] idx;
    idx = MEM_AW'(ft) * MEM_AW'(SPECIES_COUNT) + MEM_AW'(st);
    return MEM_AW'(idx * MEM_AW'(TABLE_LEN));
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_q(logic [QUOT_W-1:0] q, logic neg);
    logic signed [QUOT_W:0] v;
    v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (v > $signed((QUOT_W+1)'({1'b0, {(COORD_W-1){1'b1}}}))) begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v < -$signed((QUOT_W+1)'({1'b1, {(COORD_W-1){1'b0}}}))) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end
    return v[COORD_W-1:0];
  endfunction

  // writes from the queue head, reads for the pair sitting in stage A
  always_comb begin
    a_base = base_of(q_word_i.first_type, q_word_i.second_type);
    we     = q_pop_o && !q_word_i.is_pair
             && (32'(q_word_i.table_address) <= 32'(TABLE_BINS));
    waddr  = a_base + MEM_AW'(q_word_i.table_address);
    b_base = base_of(a_w_q.first_type, a_w_q.second_type);
    bin    = a_p_q[P_W-1:P_W-COORD_W];
    ra0    = b_base + MEM_AW'(bin);
    ra1    = ra0 + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (we) begin
        mem_q[waddr] <= q_word_i.table_word;
      end
      rd0_q <= mem_q[ra0];
      rd1_q <= mem_q[ra1];
    end
  end

  // interpolation products; the weight is the bin fraction
  always_comb begin
    logic signed [HW:0] df, de;
    df = $signed({rd1_q[WORD_W-1], rd1_q[WORD_W-1:HW]})
       - $signed({rd0_q[WORD_W-1], rd0_q[WORD_W-1:HW]});
    de = $signed({rd1_q[HW-1], rd1_q[HW-1:0]})
       - $signed({rd0_q[HW-1], rd0_q[HW-1:0]});
    c_fp_d = df * $signed({1'b0, b_t_q});
    c_ep_d = de * $signed({1'b0, b_t_q});
  end

  // bin range check folds into the contribute flag
  always_comb begin
    c_w_d         = b_w_q;
    c_w_d.contrib = b_ok_q;
  end

  always_comb begin
    logic signed [PROD_W-1:0] fs, es;
    fs = $signed(PROD_W'(c_f0_q)) + (c_fp_q >>> FRAC_W);
    es = $signed(PROD_W'(c_e0_q)) + (c_ep_q >>> FRAC_W);
    d_f_d = fs[COORD_W-1:0];
    case (c_w_q.ghosts)
      2'd0:    d_share_d = es[COORD_W-1:0];
      2'd1:    d_share_d = $signed(es[COORD_W-1:0]) >>> 1;
      default: d_share_d = '0;
    endcase
  end

  // |f| * |d_k| per lane, then seed the divider
  always_comb begin
    logic [COORD_W-1:0] magf;
    logic [DIFF_W-1:0]  magd;
    logic [N_W-1:0]     n;
    logic signed [DIFF_W-1:0] dk;
    magf = d_f_q[COORD_W-1] ? COORD_W'(-d_f_q) : COORD_W'(d_f_q);
    e_d         = '0;
    e_d.contrib = d_w_q.contrib;
    e_d.share   = d_share_q;
    e_d.root    = d_w_q.root;
    for (int k = 0; k < 3; k++) begin
      dk   = d_w_q.d[k];
      magd = dk[DIFF_W-1] ? DIFF_W'(-dk) : DIFF_W'(dk);
      n    = N_W'(N_W'(magf) * N_W'(magd));
      e_d.neg[k]       = d_f_q[COORD_W-1] ^ dk[DIFF_W-1];
      e_d.lane[k].rem  = n[QUOT_W +: ROOT_W];
      e_d.lane[k].low  = n[QUOT_W-1:0];
      e_d.lane[k].quot = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      dv_q[0] <= 1'b0;
    end else if (adv) begin
      a_vld_q <= q_pop_o && q_word_i.is_pair;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      dv_q[0] <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_w_q     <= q_word_i;
      a_p_q     <= P_W'(P_W'(q_word_i.r2) * P_W'(inv_bin_width_i));
      b_w_q     <= a_w_q;
      b_ok_q    <= a_w_q.contrib && (bin < COORD_W'(TABLE_BINS));
      b_t_q     <= a_p_q[CFG_W-1:FRAC_W];
      c_w_q     <= c_w_d;
      c_f0_q    <= rd0_q[WORD_W-1:HW];
      c_e0_q    <= rd0_q[HW-1:0];
      c_fp_q    <= c_fp_d;
      c_ep_q    <= c_ep_d;
      d_w_q     <= c_w_q;
      d_f_q     <= d_f_d;
      d_share_q <= d_share_d;
      dd_q[0]   <= e_d;
    end
  end

  // restoring divide by r, one quotient bit per stage
  for (genvar j = 0; j < QUOT_W; j++) begin : g_div
    div_t nxt;

    always_comb begin
      logic [ROOT_W:0] cur;
      nxt = dd_q[j];
      for (int k = 0; k < 3; k++) begin
        cur = {dd_q[j].lane[k].rem, dd_q[j].lane[k].low[QUOT_W-1]};
        nxt.lane[k].low = {dd_q[j].lane[k].low[QUOT_W-2:0], 1'b0};
        if (cur >= {1'b0, dd_q[j].root}) begin
          nxt.lane[k].rem  = ROOT_W'(cur - {1'b0, dd_q[j].root});
          nxt.lane[k].quot = {dd_q[j].lane[k].quot[QUOT_W-2:0], 1'b1};
        end else begin
          nxt.lane[k].rem  = cur[ROOT_W-1:0];
          nxt.lane[k].quot = {dd_q[j].lane[k].quot[QUOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (adv) begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dd_q[j+1] <= nxt;
      end
    end
  end

  always_comb begin
    o_item_o = '0;
    if (dd_q[QUOT_W].contrib) begin
      o_item_o.contributes  = 1'b1;
      o_item_o.force_x      = sat_q(dd_q[QUOT_W].lane[0].quot, dd_q[QUOT_W].neg[0]);
      o_item_o.force_y      = sat_q(dd_q[QUOT_W].lane[1].quot, dd_q[QUOT_W].neg[1]);
      o_item_o.force_z      = sat_q(dd_q[QUOT_W].lane[2].quot, dd_q[QUOT_W].neg[2]);
      o_item_o.energy_share = dd_q[QUOT_W].share;
    end
  end

endmodule
